FILE: design/acf_pkg.sv
// Shared types and constants of the adaptive acceptance filter.
package acf_pkg;

   localparam int TABLE_SLOTS    = 16;
   localparam int PROMOTE_PERIOD = 1000;

   localparam int SLOT_W       = $clog2(TABLE_SLOTS);
   localparam int ID_W         = 32;
   localparam int HIT_W        = 32;
   localparam int SLOT_FIELD_W = 4;
   localparam int FCOUNT_W     = 5;
   localparam int LIM_W        = (SLOT_W + 1 > FCOUNT_W) ? SLOT_W + 1 : FCOUNT_W;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = FCOUNT_W;

   // The promote period splits into a power of two and an odd part. A count is a
   // multiple of the period when its low bits are clear and the odd part divides it.
   function automatic int period_twos(input int period);
      int n;
      int v;
      n = 0;
      v = period;
      while ((v > 0) && ((v % 2) == 0)) begin
         v = v / 2;
         n++;
      end
      return n;
   endfunction

   // Inverse of an odd number modulo two to the counter width, by Newton iteration.
   function automatic logic [HIT_W-1:0] odd_inverse(input logic [HIT_W-1:0] d);
      logic [HIT_W-1:0] x;
      x = d;
      for (int k = 0; k < 5; k++) begin
         x = x * (HIT_W'(2) - d * x);
      end
      return x;
   endfunction

   localparam int               PER_TWOS     = period_twos(PROMOTE_PERIOD);
   localparam int               PER_ODD      = PROMOTE_PERIOD >> PER_TWOS;
   localparam logic [HIT_W-1:0] PER_LOW_MASK = HIT_W'((64'd1 << PER_TWOS) - 64'd1);
   localparam logic [HIT_W-1:0] PER_ODD_INV  = odd_inverse(HIT_W'(PER_ODD));
   localparam logic [HIT_W-1:0] PER_ODD_MAX  = {HIT_W{1'b1}} / HIT_W'(PER_ODD);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_COUNT  = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [SLOT_FIELD_W-1:0] entry_index;
      logic [ID_W-1:0]         entry_id;
      logic [ID_W-1:0]         entry_mask;
      logic                    entry_active;
      logic [ID_W-1:0]         frame_id;
   } req_word_type;

   typedef struct packed {
      logic                    accepted;
      logic                    slot_valid;
      logic [SLOT_FIELD_W-1:0] matched_slot;
      logic [HIT_W-1:0]        slot_hits;
      logic                    swapped;
      logic [HIT_W-1:0]        reject_total;
   } rsp_word_type;

   typedef struct packed {
      logic            active;
      logic [ID_W-1:0] mask;
      logic [ID_W-1:0] pattern;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] rd_addr;
      logic              ent_we;
      logic [SLOT_W-1:0] ent_waddr;
      entry_type         ent_wdata;
      logic              hit_we;
      logic [SLOT_W-1:0] hit_waddr;
      logic [HIT_W-1:0]  hit_wdata;
   } mem_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREV,
      ST_MOD,
      ST_SWAP_A,
      ST_SWAP_B
   } state_type;

endpackage

FILE: design/acf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module acf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/acf_mod_unit.sv
// Period test unit: flags a hit count that is a multiple of the promote period.
module acf_mod_unit (
   input  logic                      clock,
   input  logic                      start,
   input  logic [acf_pkg::HIT_W-1:0] value,
   output logic                      rem_zero
);
   import acf_pkg::*;

   logic [HIT_W-1:0] prod_ff, prod_in;
   logic             low_ok_ff, low_ok_in;

   // Multiplying by the inverse of the odd part maps its multiples onto the lowest
   // range of the word; the power-of-two part is a plain test of the low bits.
   always_comb begin
      prod_in   = prod_ff;
      low_ok_in = low_ok_ff;
      if (start) begin
         prod_in   = value * PER_ODD_INV;
         low_ok_in = ((value & PER_LOW_MASK) == '0);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      low_ok_ff <= low_ok_in;
   end

   assign rem_zero = low_ok_ff && (prod_ff <= PER_ODD_MAX);

endmodule

FILE: design/acf_ctrl.sv
// Sequencer of the acceptance filter: slot scan, hit update, promotion and result word.
module acf_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  acf_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   output acf_pkg::rsp_word_type        rsp_word,
   input  logic                         filter_enable,
   input  logic [acf_pkg::FCOUNT_W-1:0] filter_count,
   input  acf_pkg::entry_type           ent_rdata,
   input  logic [acf_pkg::HIT_W-1:0]    hit_rdata,
   output acf_pkg::mem_ctrl_type        mem_ctrl
);
   import acf_pkg::*;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   req_word_type      req_ff, req_in;
   entry_type         cur_ff, cur_in;
   logic [HIT_W-1:0]  hits_ff, hits_in;
   entry_type         prev_ent_ff, prev_ent_in;
   logic [HIT_W-1:0]  prev_hits_ff, prev_hits_in;
   logic [HIT_W-1:0]  reject_ff, reject_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic              accept;
   logic              match;
   logic              first_slot;
   logic              scan_last;
   logic              filter_off;
   logic              load_ok;
   logic              promote;
   logic              mod_start;
   logic              mod_zero;
   logic [HIT_W-1:0]  hits_inc;
   logic [LIM_W-1:0]  count_ext;
   logic [LIM_W-1:0]  n_eff;
   logic [LIM_W-1:0]  slot_ext;

   acf_mod_unit u_mod (
      .clock    (clock),
      .start    (mod_start),
      .value    (hits_ff),
      .rem_zero (mod_zero)
   );

   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      match      = ent_rdata.active &&
                   (((req_ff.frame_id ^ ent_rdata.pattern) & ent_rdata.mask) == '0);
      hits_inc   = hit_rdata + 1'b1;
      count_ext  = LIM_W'(filter_count);
      n_eff      = (count_ext > LIM_W'(TABLE_SLOTS)) ? LIM_W'(TABLE_SLOTS) : count_ext;
      slot_ext   = LIM_W'(scan_ff);
      scan_last  = (slot_ext == n_eff - LIM_W'(1));
      first_slot = (scan_ff == '0);
      filter_off = !filter_enable || (filter_count == '0);
      load_ok    = LIM_W'(req_word.entry_index) < LIM_W'(TABLE_SLOTS);
      promote    = mod_zero && (hits_ff > {prev_hits_ff[HIT_W-2:0], 1'b0});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.func == FUNC_CHECK) && !filter_off) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = first_slot ? ST_IDLE : ST_PREV;
            end else if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_PREV:   state_in = ST_MOD;
         ST_MOD:    state_in = promote ? ST_SWAP_A : ST_IDLE;
         ST_SWAP_A: state_in = ST_SWAP_B;
         ST_SWAP_B: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      scan_in      = scan_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      hits_in      = hits_ff;
      prev_ent_in  = prev_ent_ff;
      prev_hits_in = prev_hits_ff;
      reject_in    = reject_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.reject_total = reject_ff;
      mod_start    = 1'b0;
      mem_ctrl     = '0;
      mem_ctrl.rd_addr = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_in          = '0;
            mem_ctrl.rd_addr = '0;
            if (accept) begin
               req_in = req_word;
               if (req_word.func == FUNC_LOAD) begin
                  mem_ctrl.ent_we            = load_ok;
                  mem_ctrl.ent_waddr         = req_word.entry_index[SLOT_W-1:0];
                  mem_ctrl.ent_wdata.active  = req_word.entry_active;
                  mem_ctrl.ent_wdata.mask    = req_word.entry_mask;
                  mem_ctrl.ent_wdata.pattern = req_word.entry_id;
                  rsp_valid_in               = 1'b1;
               end else if (filter_off) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.accepted = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               cur_in             = ent_rdata;
               hits_in            = hits_inc;
               mem_ctrl.hit_we    = 1'b1;
               mem_ctrl.hit_waddr = scan_ff;
               mem_ctrl.hit_wdata = hits_inc;
               if (first_slot) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.accepted     = 1'b1;
                  rsp_in.slot_valid   = 1'b1;
                  rsp_in.matched_slot = slot_ext[SLOT_FIELD_W-1:0];
                  rsp_in.slot_hits    = hits_inc;
               end else begin
                  // Fetch the previous slot for the promotion test.
                  mem_ctrl.rd_addr = scan_ff - 1'b1;
               end
            end else if (scan_last) begin
               reject_in           = reject_ff + 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.reject_total = reject_ff + 1'b1;
            end else begin
               scan_in          = scan_ff + 1'b1;
               mem_ctrl.rd_addr = scan_ff + 1'b1;
            end
         end
         ST_PREV: begin
            prev_ent_in  = ent_rdata;
            prev_hits_in = hit_rdata;
            mod_start    = 1'b1;
         end
         ST_MOD: begin
            if (!promote) begin
               rsp_valid_in        = 1'b1;
               rsp_in.accepted     = 1'b1;
               rsp_in.slot_valid   = 1'b1;
               rsp_in.matched_slot = slot_ext[SLOT_FIELD_W-1:0];
               rsp_in.slot_hits    = hits_ff;
            end
         end
         ST_SWAP_A: begin
            mem_ctrl.ent_we    = 1'b1;
            mem_ctrl.ent_waddr = scan_ff - 1'b1;
            mem_ctrl.ent_wdata = cur_ff;
            mem_ctrl.hit_we    = 1'b1;
            mem_ctrl.hit_waddr = scan_ff - 1'b1;
            mem_ctrl.hit_wdata = hits_ff;
         end
         ST_SWAP_B: begin
            mem_ctrl.ent_we     = 1'b1;
            mem_ctrl.ent_waddr  = scan_ff;
            mem_ctrl.ent_wdata  = prev_ent_ff;
            mem_ctrl.hit_we     = 1'b1;
            mem_ctrl.hit_waddr  = scan_ff;
            mem_ctrl.hit_wdata  = prev_hits_ff;
            rsp_valid_in        = 1'b1;
            rsp_in.accepted     = 1'b1;
            rsp_in.slot_valid   = 1'b1;
            rsp_in.matched_slot = slot_ext[SLOT_FIELD_W-1:0];
            rsp_in.slot_hits    = hits_ff;
            rsp_in.swapped      = 1'b1;
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      hits_ff      <= hits_in;
      prev_ent_ff  <= prev_ent_in;
      prev_hits_ff <= prev_hits_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

FILE: design/adaptive_can_acceptance_filter_top.sv
// Top level of the adaptive acceptance filter: control registers, tables and sequencer.
//
// A word is taken on a rising edge where start is high and busy is low. A load word
// writes one table entry and a check word tests a frame identifier; both give exactly
// one result word, shown on rsp_word for a single cycle with rsp_valid high. The
// receiver cannot stall, so it must take each result word in the cycle it appears.
// A load word, and a check word while filtering is off (filter_enable low or
// filter_count zero), is finished in its accept cycle and its result appears on the
// next cycle. Otherwise the sequencer reads one table slot per cycle from the entry
// and hit-count RAMs, so a check word scans up to filter_count slots (at most the
// table size of 16). A hit in a slot other than slot zero adds a fetch of the
// previous slot, then a test in which a multiply by the inverse of the promote
// period's odd part tests the new count for a multiple of the period. A promotion
// then writes both slots back, one after the other, through the single write port
// of each RAM. The result word appears in the first cycle after busy falls, and a
// new word may be taken in that same cycle. Hit counters and the reject counter
// clear on reset; table entries must be loaded before use.
module adaptive_can_acceptance_filter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  acf_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   output acf_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_we,
   input  logic [acf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [acf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import acf_pkg::*;

   logic                filter_enable_ff, filter_enable_in;
   logic [FCOUNT_W-1:0] filter_count_ff, filter_count_in;
   logic                hit_valid_ff [TABLE_SLOTS];
   logic                hit_rd_valid_ff;

   mem_ctrl_type        mem_ctrl;
   entry_type           ent_rdata;
   logic [HIT_W-1:0]    hit_raw;
   logic [HIT_W-1:0]    hit_rdata;

   // Control registers must only be written while the block is idle; the block itself does not enforce this.
   always_comb begin
      filter_enable_in = filter_enable_ff;
      filter_count_in  = filter_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ENABLE: filter_enable_in = csr_wdata[0];
            CSR_FILTER_COUNT:  filter_count_in  = csr_wdata[FCOUNT_W-1:0];
            default: begin
               filter_enable_in = filter_enable_ff;
            end
         endcase
      end
   end

   // Hit counters reset to zero through one valid bit per slot; a slot whose valid
   // bit is clear reads as a zero count.
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         filter_count_ff  <= '0;
         hit_rd_valid_ff  <= 1'b0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            hit_valid_ff[i] <= 1'b0;
         end
      end else begin
         filter_enable_ff <= filter_enable_in;
         filter_count_ff  <= filter_count_in;
         hit_rd_valid_ff  <= hit_valid_ff[mem_ctrl.rd_addr];
         if (mem_ctrl.hit_we) begin
            hit_valid_ff[mem_ctrl.hit_waddr] <= 1'b1;
         end
      end
   end

   assign hit_rdata = hit_rd_valid_ff ? hit_raw : '0;

   acf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_ctrl.ent_we),
      .wr_addr (mem_ctrl.ent_waddr),
      .wr_data (mem_ctrl.ent_wdata),
      .rd_addr (mem_ctrl.rd_addr),
      .rd_data (ent_rdata)
   );

   acf_ram #(
      .WIDTH (HIT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_hit_ram (
      .clock   (clock),
      .wr_en   (mem_ctrl.hit_we),
      .wr_addr (mem_ctrl.hit_waddr),
      .wr_data (mem_ctrl.hit_wdata),
      .rd_addr (mem_ctrl.rd_addr),
      .rd_data (hit_raw)
   );

   acf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_word      (rsp_word),
      .filter_enable (filter_enable_ff),
      .filter_count  (filter_count_ff),
      .ent_rdata     (ent_rdata),
      .hit_rdata     (hit_rdata),
      .mem_ctrl      (mem_ctrl)
   );

endmodule
